>>> design/lwbb_pkg.sv
// ----------------------------------------------------------------------------
// lwbb_pkg: shared types and constants for the LCD window bitmap blitter
// Action codes, register indexes, the command sequence steps and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lwbb_pkg;

  // Coordinate arithmetic wraps at this width (window edges).
  localparam int COORD_BITS = 16;

  localparam int ACTION_W = 2;
  localparam int FIELD_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int IN_W     = 6 * FIELD_W + BYTE_W;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_CNT_W = 4;   // holds 0..8

  // Action codes carried in s_tuser
  localparam logic [ACTION_W-1:0] ACT_BITMAP  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FILL    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL_CMD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_CMD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_CMD  = 2'd2;

  localparam logic [BYTE_W-1:0] COL_CMD_RESET  = 8'd42;
  localparam logic [BYTE_W-1:0] PAGE_CMD_RESET = 8'd43;
  localparam logic [BYTE_W-1:0] MEM_CMD_RESET  = 8'd44;

  // Words of the window set-up sequence, in bus order
  typedef enum logic [2:0] {
    SEQ_COL_CMD  = 3'd0,
    SEQ_X0       = 3'd1,
    SEQ_X1       = 3'd2,
    SEQ_PAGE_CMD = 3'd3,
    SEQ_Y0       = 3'd4,
    SEQ_Y1       = 3'd5,
    SEQ_MEM_CMD  = 3'd6
  } seq_step_t;

  typedef struct packed {
    logic      load_start;  // latch a start word
    logic      load_adv;    // latch an advance word
    logic      emit_seq;    // put one set-up word on the output
    logic      emit_pix;    // put one pixel word on the output
    seq_step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;   // input word is a bitmap or fill start
    logic is_adv;     // input word is an advance with a draw in progress
    logic out_free;   // output register can take a word this cycle
    logic pix_final;  // the next pixel word is the last of this byte
  } dp_status_t;

endpackage

>>> design/lwbb_ctrl.sv
// ----------------------------------------------------------------------------
// lwbb_ctrl: sequencer for the LCD window bitmap blitter
// Accepts one input word at a time, then steps the datapath through the
// set-up command sequence or the pixel words of one image byte.
// ----------------------------------------------------------------------------
module lwbb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lwbb_pkg::dp_status_t status,
  output lwbb_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEQ,
    ST_PIX
  } state_t;

  state_t              state;
  lwbb_pkg::seq_step_t step;
  logic                accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.load_start = accept && status.is_start;
    cmd.load_adv   = accept && status.is_adv;
    cmd.emit_seq   = (state == ST_SEQ) && status.out_free;
    cmd.emit_pix   = (state == ST_PIX) && status.out_free;
    cmd.step       = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= lwbb_pkg::SEQ_COL_CMD;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= lwbb_pkg::SEQ_COL_CMD;
          if (cmd.load_start) begin
            state <= ST_SEQ;
          end else if (cmd.load_adv) begin
            state <= ST_PIX;
          end
        end
        ST_SEQ: begin
          if (status.out_free) begin
            if (step == lwbb_pkg::SEQ_MEM_CMD) begin
              state <= ST_IDLE;
            end else begin
              step <= lwbb_pkg::seq_step_t'(step + 3'd1);
            end
          end
        end
        ST_PIX: begin
          if (status.out_free && status.pix_final) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/lwbb_dp.sv
// ----------------------------------------------------------------------------
// lwbb_dp: datapath for the LCD window bitmap blitter
// Config registers, window edges, draw position, pixel shifter and the
// output register.
// ----------------------------------------------------------------------------
module lwbb_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [lwbb_pkg::IN_W-1:0]          s_tdata,
  input  logic [lwbb_pkg::ACTION_W-1:0]      s_tuser,
  input  logic                               cfg_valid,
  input  logic [lwbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lwbb_pkg::BYTE_W-1:0]        cfg_data,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lwbb_pkg::FIELD_W-1:0]       m_tdata,
  output logic                               m_tuser,
  output logic                               m_tlast,
  input  lwbb_pkg::dp_cmd_t                  cmd,
  output lwbb_pkg::dp_status_t               status
);

  localparam int CB = lwbb_pkg::COORD_BITS;
  localparam int FW = lwbb_pkg::FIELD_W;

  // input word fields
  logic [FW-1:0] center_x, width_pixels, center_y, height_pixels, fore_color, bg_color;
  logic [lwbb_pkg::BYTE_W-1:0] image_byte;

  assign center_x      = s_tdata[0*FW +: FW];
  assign width_pixels  = s_tdata[1*FW +: FW];
  assign center_y      = s_tdata[2*FW +: FW];
  assign height_pixels = s_tdata[3*FW +: FW];
  assign fore_color    = s_tdata[4*FW +: FW];
  assign bg_color      = s_tdata[5*FW +: FW];
  assign image_byte    = s_tdata[6*FW +: lwbb_pkg::BYTE_W];

  logic [lwbb_pkg::BYTE_W-1:0] col_cmd, page_cmd, mem_cmd;

  logic          drawing, fill_mode, empty, draw_done;
  logic [FW-1:0] column_count, row_count, window_width, window_height;
  logic [FW-1:0] saved_fg, saved_bg;
  logic [CB-1:0] x0, x1, y0, y1;
  logic [lwbb_pkg::BYTE_W-1:0]    shifter;
  logic [lwbb_pkg::PIX_CNT_W-1:0] pix_left;

  // window edges: lo = c - len/2, hi = c + len/2 - (len even)
  logic [CB-1:0] x_half, y_half, x0_c, x1_c, y0_c, y1_c;
  assign x_half = CB'(width_pixels >> 1);
  assign y_half = CB'(height_pixels >> 1);
  assign x0_c = center_x[CB-1:0] - x_half;
  assign x1_c = center_x[CB-1:0] + x_half - CB'(!width_pixels[0]);
  assign y0_c = center_y[CB-1:0] - y_half;
  assign y1_c = center_y[CB-1:0] + y_half - CB'(!height_pixels[0]);

  // pixels in this byte: rest of the row, at most eight
  logic [FW-1:0]                  remain;
  logic                           row_done, draw_done_c;
  logic [lwbb_pkg::PIX_CNT_W-1:0] n_pix;
  logic [FW:0]                    row_next;
  assign remain      = window_width - column_count;
  assign row_done    = (remain <= FW'(8));
  assign n_pix       = row_done ? remain[lwbb_pkg::PIX_CNT_W-1:0]
                                : lwbb_pkg::PIX_CNT_W'(8);
  assign row_next    = {1'b0, row_count} + (FW+1)'(1);
  assign draw_done_c = row_done && (row_next >= {1'b0, window_height});

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    status.is_start  = (s_tuser == lwbb_pkg::ACT_BITMAP) || (s_tuser == lwbb_pkg::ACT_FILL);
    status.is_adv    = (s_tuser == lwbb_pkg::ACT_ADVANCE) && drawing;
    status.out_free  = out_free;
    status.pix_final = (pix_left == lwbb_pkg::PIX_CNT_W'(1));
  end

  // set-up sequence word
  logic [FW-1:0] seq_value;
  logic          seq_is_cmd, seq_last;
  always_comb begin
    seq_value  = '0;
    seq_is_cmd = 1'b0;
    seq_last   = 1'b0;
    unique case (cmd.step)
      lwbb_pkg::SEQ_COL_CMD: begin
        seq_value  = FW'(col_cmd);
        seq_is_cmd = 1'b1;
      end
      lwbb_pkg::SEQ_X0:       seq_value = FW'(x0);
      lwbb_pkg::SEQ_X1:       seq_value = FW'(x1);
      lwbb_pkg::SEQ_PAGE_CMD: begin
        seq_value  = FW'(page_cmd);
        seq_is_cmd = 1'b1;
      end
      lwbb_pkg::SEQ_Y0:       seq_value = FW'(y0);
      lwbb_pkg::SEQ_Y1:       seq_value = FW'(y1);
      lwbb_pkg::SEQ_MEM_CMD: begin
        seq_value  = FW'(mem_cmd);
        seq_is_cmd = 1'b1;
        seq_last   = empty;
      end
      default: seq_value = '0;
    endcase
  end

  // config registers; the port is always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cmd  <= lwbb_pkg::COL_CMD_RESET;
      page_cmd <= lwbb_pkg::PAGE_CMD_RESET;
      mem_cmd  <= lwbb_pkg::MEM_CMD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == lwbb_pkg::REG_COL_CMD)  col_cmd  <= cfg_data;
      if (cfg_index == lwbb_pkg::REG_PAGE_CMD) page_cmd <= cfg_data;
      if (cfg_index == lwbb_pkg::REG_MEM_CMD)  mem_cmd  <= cfg_data;
    end
  end

  // draw state
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing       <= 1'b0;
      fill_mode     <= 1'b0;
      empty         <= 1'b0;
      draw_done     <= 1'b0;
      column_count  <= '0;
      row_count     <= '0;
      window_width  <= '0;
      window_height <= '0;
      saved_fg      <= '0;
      saved_bg      <= '0;
      x0            <= '0;
      x1            <= '0;
      y0            <= '0;
      y1            <= '0;
      shifter       <= '0;
      pix_left      <= '0;
    end else if (cmd.load_start) begin
      fill_mode     <= (s_tuser == lwbb_pkg::ACT_FILL);
      window_width  <= width_pixels;
      window_height <= height_pixels;
      saved_fg      <= fore_color;
      saved_bg      <= bg_color;
      column_count  <= '0;
      row_count     <= '0;
      empty         <= (width_pixels == '0) || (height_pixels == '0);
      drawing       <= (width_pixels != '0) && (height_pixels != '0);
      x0            <= x0_c;
      x1            <= x1_c;
      y0            <= y0_c;
      y1            <= y1_c;
    end else if (cmd.load_adv) begin
      shifter   <= image_byte;
      pix_left  <= n_pix;
      draw_done <= draw_done_c;
      if (row_done) begin
        column_count <= '0;
        row_count    <= row_next[FW-1:0];
      end else begin
        column_count <= column_count + FW'(n_pix);
      end
      if (draw_done_c) drawing <= 1'b0;
    end else if (cmd.emit_pix) begin
      shifter  <= {shifter[lwbb_pkg::BYTE_W-2:0], 1'b0};
      pix_left <= pix_left - lwbb_pkg::PIX_CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_seq || cmd.emit_pix) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seq) begin
      m_tdata <= seq_value;
      m_tuser <= seq_is_cmd;
      m_tlast <= seq_last;
    end else if (cmd.emit_pix) begin
      m_tdata <= (fill_mode || shifter[lwbb_pkg::BYTE_W-1]) ? saved_fg : saved_bg;
      m_tuser <= 1'b0;
      m_tlast <= draw_done && status.pix_final;
    end
  end

endmodule

>>> design/lcd_window_bitmap_blitter.sv
// ----------------------------------------------------------------------------
// lcd_window_bitmap_blitter: draw requests to LCD controller bus words
// Turns window start and image byte words into command and pixel words.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per draw request. s_tuser carries the
//   action (bitmap start, fill start, advance). Start words give the
//   centered window and colors; advance words give one image byte.
//   Output stream (m_*): one bus word per transaction. m_tuser = 1 marks a
//   command byte (low 8 bits of m_tdata), 0 a 16-bit pixel/data word.
//   m_tlast flags the final word of the whole draw.
//   Config port (cfg_*): always ready; writes the column, page and memory
//   write command bytes. Write only while the block is idle.
// Timing:
//   A start word passes the state register and then the output register
//   before the first set-up word is valid; all seven leave one per cycle
//   while m_tready stays high. An advance word gives n pixel words, n =
//   pixels in the byte (up to 8, fewer at a row end). The single output
//   register sets the pace; one input word is in work at a time. Advance
//   words with no draw open, and unused actions, give no output.
// Reset: command registers go to 42/43/44, no draw is open, output empty.
// Stall: a low m_tready holds the output word and pauses the sequence;
//   s_tready stays low until the last word sits in the output register.
// ----------------------------------------------------------------------------
module lcd_window_bitmap_blitter (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata, from bit 0: center_x, width_pixels, center_y, height_pixels,
  //                      fore_color, bg_color, image_byte
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [lwbb_pkg::IN_W-1:0]      s_tdata,
  input  logic [lwbb_pkg::ACTION_W-1:0]  s_tuser,    // action
  // m_tdata: bus_value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [lwbb_pkg::FIELD_W-1:0]   m_tdata,
  output logic                           m_tuser,    // is_command
  output logic                           m_tlast,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lwbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lwbb_pkg::BYTE_W-1:0]    cfg_data
);

  lwbb_pkg::dp_cmd_t    cmd;
  lwbb_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  lwbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lwbb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

  // a start word always opens a set-up sequence, so input stays blocked
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == lwbb_pkg::ACT_BITMAP || s_tuser == lwbb_pkg::ACT_FILL)
    |=> !s_tready)
    else $error("start word did not begin a set-up sequence");

  // unused action code produces nothing
  a_unused_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    !(s_tuser == lwbb_pkg::ACT_BITMAP || s_tuser == lwbb_pkg::ACT_FILL ||
      s_tuser == lwbb_pkg::ACT_ADVANCE)
    |=> s_tready)
    else $error("unused action started work");

  // command words carry a byte only
  a_cmd_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[lwbb_pkg::FIELD_W-1:lwbb_pkg::BYTE_W] == '0)
    else $error("command word has upper bits set");

endmodule
